// ===== sv/lcdns_pkg.sv =====
`timescale 1ns / 1ps
// Package for the character LCD nibble sequencer.
// Holds request codes, register indexes, sequence constants and the
// controller/datapath interface types. No dependencies.
package lcdns_pkg;

	// Request codes
	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_COMMAND = 2'd1,
		OP_DATA    = 2'd2,
		OP_MOVE    = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ENABLE_HALF = 2'd0,
		REG_BYTE_SETTLE = 2'd1,
		REG_LONG_CMD    = 2'd2,
		REG_POWER_UP    = 2'd3
	} reg_idx_t;

	// Controller states
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	localparam int unsigned SETTLE_W = 17;
	localparam int unsigned POWER_W  = 20;
	localparam int unsigned WAIT_W   = 21;
	localparam int unsigned CFG_W    = 20;
	localparam int unsigned STEP_W   = 4;

	// Step layout of the init run: power-up wait, three reset nibbles, the four-bit nibble, four bytes
	localparam logic [STEP_W-1:0] STEP_POWER      = 4'd0;
	localparam logic [STEP_W-1:0] STEP_RESET_A    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_RESET_B    = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RESET_C    = 4'd3;
	localparam logic [STEP_W-1:0] FIRST_BYTE_STEP = 4'd5;
	localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd12;
	localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 4'd1;

	localparam logic [3:0] RESET_NIBBLE    = 4'h3;
	localparam logic [3:0] FOUR_BIT_NIBBLE = 4'h2;
	localparam logic [WAIT_W-1:0] WAIT_RESET_A = 21'd5000;
	localparam logic [WAIT_W-1:0] WAIT_RESET_B = 21'd150;

	localparam logic [7:0] LONG_CMD_LIMIT = 8'h04;
	localparam logic [7:0] ROW1_BASE      = 8'h80;
	localparam logic [7:0] ROW2_BASE      = 8'hC0;

	// Bytes sent at the end of init: function set, entry mode, display on, clear
	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0:    b = 8'h28;
			2'd1:    b = 8'h06;
			2'd2:    b = 8'h0C;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

	// Controller to datapath
	typedef struct packed {
		logic load;   // capture request, clear step counter
		logic emit;   // register current action, advance step
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req_empty;  // request on the inputs produces no actions
		logic step_last;  // current step is the final action of the run
	} stat_t;

endpackage

// ===== sv/char_lcd_nibble_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the 4-bit character LCD nibble sequencer.
// Depends on lcdns_pkg, lcdns_ctrl and lcdns_dp.
//
// A request is taken when start is high and busy is low. Busy rises in the
// next cycle, and in the cycle after that the first pin action shows on the
// result ports; each action is shown for one cycle with strobe high, and the
// receiver must take every strobed action. Init gives 13 actions, command,
// data and cursor-move requests give 2, a move to a row other than 1 or 2
// gives none and does not raise busy. One action per cycle is set by the step
// counter in the datapath; a new request may be given in the cycle that shows
// the final action (last high). Config writes are always ready and take
// effect on the next action computed.
module char_lcd_nibble_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    operation,
	input  logic [7:0]                    byte_value,
	input  logic [1:0]                    row,
	input  logic [5:0]                    column,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [lcdns_pkg::CFG_W-1:0]   cfg_data,
	output logic                          strobe,
	output logic                          register_select,
	output logic [3:0]                    nibble,
	output logic                          pulse_enable,
	output logic [lcdns_pkg::WAIT_W-1:0]  wait_us,
	output logic                          last
);
	import lcdns_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	lcdns_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lcdns_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.operation       (operation),
		.byte_value      (byte_value),
		.row             (row),
		.column          (column),
		.cfg_write       (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.strobe          (strobe),
		.register_select (register_select),
		.nibble          (nibble),
		.pulse_enable    (pulse_enable),
		.wait_us         (wait_us),
		.last            (last)
	);

	// A strobed action always comes from a running request
	a_strobe_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("action strobed without a running request");

	// Actions of one run come back to back until the final one
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside an action run");

	// The final action leaves the block free for the next request
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> !busy)
		else $error("still busy on final action");

	// A request with actions starts a run
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !stat.req_empty) |=> (busy && !cmd.load))
		else $error("accepted request did not start a run");

endmodule

// ===== sv/lcdns_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the LCD nibble sequencer.
// Depends on lcdns_pkg.
module lcdns_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lcdns_pkg::stat_t stat,
	output lcdns_pkg::cmd_t  cmd,
	output logic           busy
);
	import lcdns_pkg::*;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!stat.req_empty) begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				busy     = 1'b1;
				cmd.emit = 1'b1;
				if (stat.step_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== sv/lcdns_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the LCD nibble sequencer: configuration registers, request
// capture, step counter, action decode and result register. Depends on lcdns_pkg.
module lcdns_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lcdns_pkg::cmd_t                     cmd,
	output lcdns_pkg::stat_t                    stat,
	input  logic [1:0]                          operation,
	input  logic [7:0]                          byte_value,
	input  logic [1:0]                          row,
	input  logic [5:0]                          column,
	input  logic                                cfg_write,
	input  logic [1:0]                          cfg_index,
	input  logic [lcdns_pkg::CFG_W-1:0]         cfg_data,
	output logic                                strobe,
	output logic                                register_select,
	output logic [3:0]                          nibble,
	output logic                                pulse_enable,
	output logic [lcdns_pkg::WAIT_W-1:0]        wait_us,
	output logic                                last
);
	import lcdns_pkg::*;

	logic [SETTLE_W-1:0] settle_q;
	logic [SETTLE_W-1:0] long_q;
	logic [POWER_W-1:0]  power_q;

	op_t               op_q;
	logic [7:0]        byte_q;
	logic [STEP_W-1:0] step_q;

	logic              strobe_q;
	logic              rs_q;
	logic [3:0]        nib_q;
	logic              pulse_q;
	logic [WAIT_W-1:0] wait_q;
	logic              last_q;

	op_t               op_in;
	logic [7:0]        move_base;
	logic [7:0]        load_byte;
	logic              req_empty_w;
	logic              init_w;
	logic              rs_w;
	logic [STEP_W-1:0] byte_step;
	logic [7:0]        cur_byte;
	logic              lo_half;
	logic              long_w;
	logic [WAIT_W-1:0] byte_wait;
	logic [3:0]        nib_w;
	logic              pulse_w;
	logic [WAIT_W-1:0] wait_w;
	logic              last_w;

	// Configuration registers; E pulse timing is applied by the pin driver,
	// so index REG_ENABLE_HALF is taken and has no effect here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 17'd50;
			long_q   <= 17'd2000;
			power_q  <= 20'd50000;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BYTE_SETTLE: settle_q <= cfg_data[SETTLE_W-1:0];
				REG_LONG_CMD:    long_q   <= cfg_data[SETTLE_W-1:0];
				REG_POWER_UP:    power_q  <= cfg_data[POWER_W-1:0];
				default:         ;
			endcase
		end
	end

	// Request decode: move becomes a set-address command byte
	always_comb begin
		op_in       = op_t'(operation);
		move_base   = (row == 2'd1) ? ROW1_BASE : ROW2_BASE;
		load_byte   = (op_in == OP_MOVE) ? (move_base + {2'b00, column} - 8'd1) : byte_value;
		req_empty_w = (op_in == OP_MOVE) && (row != 2'd1) && (row != 2'd2);
	end

	// Request and step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_INIT;
			step_q <= '0;
		end else if (cmd.load) begin
			op_q   <= op_in;
			step_q <= '0;
		end else if (cmd.emit) begin
			step_q <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= load_byte;
		end
	end

	// Action for the current step
	always_comb begin
		init_w    = (op_q == OP_INIT);
		rs_w      = (op_q == OP_DATA);
		byte_step = step_q - FIRST_BYTE_STEP;
		cur_byte  = init_w ? init_byte(byte_step[2:1]) : byte_q;
		lo_half   = init_w ? byte_step[0] : step_q[0];
		long_w    = !rs_w && (cur_byte < LONG_CMD_LIMIT);
		byte_wait = {4'b0, settle_q} + (long_w ? {4'b0, long_q} : '0);
		nib_w     = lo_half ? cur_byte[3:0] : cur_byte[7:4];
		pulse_w   = 1'b1;
		wait_w    = lo_half ? byte_wait : '0;
		if (init_w && (step_q < FIRST_BYTE_STEP)) begin
			unique case (step_q)
				STEP_POWER: begin
					nib_w   = 4'h0;
					pulse_w = 1'b0;
					wait_w  = {1'b0, power_q};
				end
				STEP_RESET_A: begin
					nib_w  = RESET_NIBBLE;
					wait_w = WAIT_RESET_A;
				end
				STEP_RESET_B: begin
					nib_w  = RESET_NIBBLE;
					wait_w = WAIT_RESET_B;
				end
				STEP_RESET_C: begin
					nib_w  = RESET_NIBBLE;
					wait_w = '0;
				end
				default: begin
					nib_w  = FOUR_BIT_NIBBLE;
					wait_w = '0;
				end
			endcase
		end
		last_w = init_w ? (step_q == INIT_LAST_STEP) : (step_q == BYTE_LAST_STEP);
	end

	// Status back to the controller
	assign stat = '{req_empty: req_empty_w, step_last: last_w};

	// Result register: one strobe cycle per action
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rs_q    <= rs_w;
			nib_q   <= nib_w;
			pulse_q <= pulse_w;
			wait_q  <= wait_w;
			last_q  <= last_w;
		end
	end

	assign strobe          = strobe_q;
	assign register_select = rs_q;
	assign nibble          = nib_q;
	assign pulse_enable    = pulse_q;
	assign wait_us         = wait_q;
	assign last            = last_q;

endmodule
